// ===== hdl/skw_pkg.sv =====
// Shared types and constants for the skinning weight renormaliser.
package skw_pkg;

    localparam int BONE_W   = 10;
    localparam int CLOTH_W  = 11;
    localparam int WEIGHT_W = 17;
    localparam int SUM_W    = 20;
    localparam int SLOT_W   = 3;

    localparam logic [WEIGHT_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [SUM_W-1:0]    SUM_MAX     = 20'hFFFFF;
    localparam logic [CLOTH_W-1:0]  CLOTH_RESET = 11'h7FF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int QUOT_W    = 18;
    localparam int DIV_ITERS = QUOT_W / 2;
    localparam int CNT_W     = $clog2(DIV_ITERS + 1);

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [WEIGHT_W-1:0] weight;
        logic [SUM_W-1:0]    sum;
        logic                last;
        logic                too_many;
    } skw_job_t;

endpackage

// ===== hdl/skw_front.sv =====
// Front end: collects a vertex's attachments, then hands one division job per slot.
module skw_front
    import skw_pkg::*;
#(
    parameter int MAX_ATTACH = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CLOTH_W-1:0]  cloth_bone_id,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BONE_W-1:0]   in_bone,
    input  logic [WEIGHT_W-1:0] in_weight,
    input  logic                in_last,
    output logic                job_valid,
    input  logic                job_ready,
    output skw_job_t            job
);

    localparam int CW = $clog2(MAX_ATTACH + 1);
    localparam int IW = (MAX_ATTACH > 1) ? $clog2(MAX_ATTACH) : 1;

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_DRAIN   = 1'b1;

    logic                state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                ovf_reg, ovf_next;
    logic [IW-1:0]       rd_reg, rd_next;
    logic [WEIGHT_W-1:0] store [MAX_ATTACH];

    logic                wr_en;
    logic [WEIGHT_W-1:0] wr_data;
    logic                cloth_hit;
    logic [SUM_W:0]      sum_ext;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        rd_next    = rd_reg;
        wr_en      = 1'b0;
        wr_data    = in_weight;

        in_ready  = (state_reg == ST_COLLECT);
        job_valid = (state_reg == ST_DRAIN);

        job.slot     = SLOT_W'(rd_reg);
        job.weight   = store[rd_reg];
        job.sum      = sum_reg;
        job.last     = ((CW'(rd_reg) + CW'(1)) == count_reg);
        job.too_many = ovf_reg;

        cloth_hit = !cloth_bone_id[CLOTH_W-1] && (in_bone == cloth_bone_id[BONE_W-1:0]);
        sum_ext   = {1'b0, sum_reg} + (SUM_W+1)'(in_weight);

        if (in_valid && in_ready) begin
            if (count_reg < CW'(MAX_ATTACH)) begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                if (cloth_hit) begin
                    wr_data = '0;
                end else begin
                    sum_next = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                end
            end else begin
                ovf_next = 1'b1;
            end
            if (in_last) begin
                state_next = ST_DRAIN;
                rd_next    = '0;
            end
        end

        if (job_valid && job_ready) begin
            if (job.last) begin
                state_next = ST_COLLECT;
                count_next = '0;
                sum_next   = '0;
                ovf_next   = 1'b0;
            end else begin
                rd_next = rd_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            rd_reg    <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[count_reg[IW-1:0]] <= wr_data;
        end
    end

endmodule

// ===== hdl/skw_queue.sv =====
// Short job queue between the front end and the divider.
module skw_queue
    import skw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  skw_job_t wr_job,
    output logic     rd_valid,
    input  logic     rd_ready,
    output skw_job_t rd_job
);

    skw_job_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   wp_reg, rp_reg;

    assign wr_ready = ((wp_reg - rp_reg) != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (wp_reg != rp_reg);
    assign rd_job   = mem[rp_reg[QUEUE_AW-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) begin
                wp_reg <= wp_reg + (QUEUE_AW+1)'(1);
            end
            if (rd_valid && rd_ready) begin
                rp_reg <= rp_reg + (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) begin
            mem[wp_reg[QUEUE_AW-1:0]] <= wr_job;
        end
    end

endmodule

// ===== hdl/skw_back.sv =====
// Back end: radix-4 restoring divider and the result output register.
module skw_back
    import skw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  skw_job_t            job,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [WEIGHT_W-1:0] out_weight,
    output logic                out_last,
    output logic                out_too_many
);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W:0]      rem_reg, rem_next;
    logic [QUOT_W-1:0]   dvd_reg, dvd_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [SUM_W-1:0]    divisor_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                last_reg;
    logic                tm_reg;
    logic                zero_reg;

    logic                out_valid_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;
    logic                out_last_reg;
    logic                out_tm_reg;

    logic                done;
    logic                out_free;
    logic [SUM_W:0]      trial;
    logic [WEIGHT_W-1:0] result;

    assign job_ready = !busy_reg;
    assign done      = busy_reg && (cnt_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        trial     = '0;
        for (int i = 0; i < 2; i++) begin
            trial    = {rem_next[SUM_W-1:0], dvd_next[QUOT_W-1]};
            dvd_next = {dvd_next[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg}) begin
                rem_next  = trial - {1'b0, divisor_reg};
                quot_next = {quot_next[QUOT_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_next[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (zero_reg) begin
            result = weight_reg;
        end else if (quot_reg > QUOT_W'(ONE_Q16)) begin
            result = ONE_Q16;
        end else begin
            result = quot_reg[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (job_valid && job_ready) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_ITERS);
            end else if (busy_reg && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end else if (done && out_free) begin
                busy_reg <= 1'b0;
            end
            if (done && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            rem_reg     <= (SUM_W+1)'(job.weight[WEIGHT_W-1:2]);
            dvd_reg     <= {job.weight[1:0], 16'b0};
            quot_reg    <= '0;
            divisor_reg <= job.sum;
            weight_reg  <= job.weight;
            slot_reg    <= job.slot;
            last_reg    <= job.last;
            tm_reg      <= job.too_many;
            zero_reg    <= (job.sum == '0);
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            quot_reg <= quot_next;
        end
        if (done && out_free) begin
            out_slot_reg   <= slot_reg;
            out_weight_reg <= result;
            out_last_reg   <= last_reg;
            out_tm_reg     <= tm_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_slot     = out_slot_reg;
    assign out_weight   = out_weight_reg;
    assign out_last     = out_last_reg;
    assign out_too_many = out_tm_reg;

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_weight_reg <= ONE_Q16))
        else $error("result weight above one");

    a_job_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && job_ready) |=> (busy_reg && cnt_reg == CNT_W'(DIV_ITERS)))
        else $error("division did not start on job pop");

    a_iter_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg != '0) |=> (busy_reg && cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("divider step counter slipped");

endmodule

// ===== hdl/skin_weight_renormalizer.sv =====
// Top level of the skinning weight renormaliser.
//
// Input beats carry one bone attachment each: s_tdata holds bone id and weight, s_tlast
// closes the vertex. Attachments whose bone equals the cloth bone register are stored as
// zero; the rest are summed with saturation. Beyond MAX_ATTACH slots an attachment is
// dropped and the vertex is flagged. cfg_data writes the cloth bone (-1 disables it).
// After the closing beat the front end hands one job per stored slot to a four-entry
// queue, one a cycle while the queue has room, and holds s_tready low meanwhile. Other
// beats are taken one a cycle. The back end divides weight * 65536 by the sum with a
// radix-4 restoring divider and takes a new job only once the last result has entered
// the output register. Results leave in slot order through that register; when m_tready
// is low it holds, the divider waits, the queue fills and the front end stalls in turn.
// Reset clears all control state and sets the cloth bone to -1; the slot store needs
// no clearing.
module skin_weight_renormalizer
    import skw_pkg::*;
#(
    parameter int MAX_ATTACH = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CLOTH_W-1:0] cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // bone_id [9:0], weight [26:10], zero [31:27]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // slot [2:0], new_weight [19:3], zero [23:20]
    output logic               m_tlast,
    output logic               m_tuser    // too_many
);

    logic [CLOTH_W-1:0]  cloth_reg;
    logic                fj_valid, fj_ready, bj_valid, bj_ready;
    skw_job_t            fj, bj;
    logic [SLOT_W-1:0]   out_slot;
    logic [WEIGHT_W-1:0] out_weight;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cloth_reg <= CLOTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cloth_reg <= cfg_data;
        end
    end

    skw_front #(.MAX_ATTACH(MAX_ATTACH)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cloth_bone_id (cloth_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_bone       (s_tdata[BONE_W-1:0]),
        .in_weight     (s_tdata[BONE_W+WEIGHT_W-1:BONE_W]),
        .in_last       (s_tlast),
        .job_valid     (fj_valid),
        .job_ready     (fj_ready),
        .job           (fj)
    );

    skw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_job   (fj),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_job   (bj)
    );

    skw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (bj_valid),
        .job_ready    (bj_ready),
        .job          (bj),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_slot     (out_slot),
        .out_weight   (out_weight),
        .out_last     (m_tlast),
        .out_too_many (m_tuser)
    );

    assign m_tdata = {4'b0, out_weight, out_slot};

endmodule

// ===== sim/tb_skin_weight_renormalizer.sv =====
// Self-checking testbench for the skinning weight renormaliser: directed and random vertices.
`timescale 1ns / 1ps

class weight_scoreboard #(int SLOTS = 6);

    typedef struct {
        logic [skw_pkg::SLOT_W-1:0]   slot;
        logic [skw_pkg::WEIGHT_W-1:0] new_weight;
        logic                         last;
        logic                         too_many;
    } weight_result_t;

    logic [skw_pkg::CLOTH_W-1:0]  cloth_bone;
    logic [skw_pkg::WEIGHT_W-1:0] slot_weight [SLOTS];
    int unsigned                  slot_count;
    logic [skw_pkg::SUM_W-1:0]    total_weight;
    bit                           dropped;
    weight_result_t               expected_q [$];
    int                           errors;
    int                           checked;
    int                           vertices;
    int                           overflowed;
    int                           zero_sums;
    int                           cloth_hits;

    function new();
        cloth_bone = skw_pkg::CLOTH_RESET;
        errors     = 0;
        checked    = 0;
        vertices   = 0;
        overflowed = 0;
        zero_sums  = 0;
        cloth_hits = 0;
        clear_vertex();
    endfunction

    function void clear_vertex();
        slot_count   = 0;
        total_weight = '0;
        dropped      = 1'b0;
    endfunction

    task report(input string msg);
        errors++;
        if (errors <= 30) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function void note_attachment(input logic [skw_pkg::BONE_W-1:0] bone,
                                  input logic [skw_pkg::WEIGHT_W-1:0] weight,
                                  input logic last);
        logic [skw_pkg::SUM_W:0] acc;
        logic [63:0]             quot;
        weight_result_t          r;
        int                      k;
        if (slot_count < SLOTS) begin
            if (!cloth_bone[skw_pkg::CLOTH_W-1] && cloth_bone == {1'b0, bone}) begin
                slot_weight[slot_count] = '0;
                cloth_hits++;
            end else begin
                slot_weight[slot_count] = weight;
                acc = {1'b0, total_weight} + weight;
                total_weight = (acc > skw_pkg::SUM_MAX) ? skw_pkg::SUM_MAX
                                                        : acc[skw_pkg::SUM_W-1:0];
            end
            slot_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!last) begin
            return;
        end
        if (total_weight == 0) begin
            zero_sums++;
        end
        for (k = 0; k < slot_count; k++) begin
            if (total_weight != 0) begin
                quot = ({47'd0, slot_weight[k]} << 16) / total_weight;
                if (quot > skw_pkg::ONE_Q16) begin
                    quot = skw_pkg::ONE_Q16;
                end
            end else begin
                quot = slot_weight[k];
            end
            r.slot       = 3'(k);
            r.new_weight = quot[skw_pkg::WEIGHT_W-1:0];
            r.last       = (k == slot_count - 1);
            r.too_many   = dropped;
            expected_q.push_back(r);
        end
        vertices++;
        if (dropped) begin
            overflowed++;
        end
        clear_vertex();
    endfunction

    task check_result(input logic [skw_pkg::SLOT_W-1:0] slot,
                      input logic [skw_pkg::WEIGHT_W-1:0] new_weight,
                      input logic last,
                      input logic too_many);
        weight_result_t e;
        checked++;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected beat slot %0d weight %0d", slot, new_weight));
            return;
        end
        e = expected_q.pop_front();
        if (slot !== e.slot) begin
            report($sformatf("slot %0d, want %0d", slot, e.slot));
        end
        if (new_weight !== e.new_weight) begin
            report($sformatf("slot %0d weight %0d, want %0d", e.slot, new_weight, e.new_weight));
        end
        if (last !== e.last) begin
            report($sformatf("slot %0d tlast %0b, want %0b", e.slot, last, e.last));
        end
        if (too_many !== e.too_many) begin
            report($sformatf("slot %0d tuser %0b, want %0b", e.slot, too_many, e.too_many));
        end
    endtask

endclass

module tb_skin_weight_renormalizer;
    import skw_pkg::*;

    localparam int                 MAX_ATTACH  = 6;
    localparam int                 STALL_LIMIT = 2000;
    localparam logic [CLOTH_W-1:0] CLOTH_NONE  = CLOTH_RESET;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CLOTH_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata   = '0;   // bone_id [9:0], weight [26:10], zero [31:27]
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;          // slot [2:0], new_weight [19:3], zero [23:20]
    logic               m_tlast;
    logic               m_tuser;          // too_many

    weight_scoreboard #(MAX_ATTACH) sb;
    bit quiet_stretch = 1'b0;
    int stall_cycles  = 0;
    int items_sent    = 0;

    skin_weight_renormalizer #(.MAX_ATTACH(MAX_ATTACH)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= quiet_stretch || ($urandom_range(99) >= 36);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_attachment(s_tdata[9:0], s_tdata[26:10], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata[2:0], m_tdata[19:3], m_tlast, m_tuser);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic send_attachment(input logic [BONE_W-1:0] bone,
                                   input logic [WEIGHT_W-1:0] weight,
                                   input logic last);
        @(negedge aclk);
        while (!quiet_stretch && $urandom_range(99) < 36) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'd0, weight, bone};
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    // hold off the sender until every expected beat has left
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_cloth(input logic [CLOTH_W-1:0] bone);
        drain();
        repeat (20) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = bone;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        sb.cloth_bone = bone;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_vertex();
        int                  count;
        int                  i;
        logic [BONE_W-1:0]   bone;
        logic [WEIGHT_W-1:0] weight;
        count = ($urandom_range(99) < 15) ? $urandom_range(10, 7) : $urandom_range(MAX_ATTACH, 1);
        for (i = 0; i < count; i++) begin
            if (!sb.cloth_bone[CLOTH_W-1] && $urandom_range(3) == 0) begin
                bone = sb.cloth_bone[BONE_W-1:0];
            end else begin
                bone = BONE_W'($urandom_range(1023));
            end
            case ($urandom_range(7))
                0: begin
                    weight = '0;
                end
                1: begin
                    weight = ONE_Q16;
                end
                2: begin
                    weight = WEIGHT_W'($urandom_range(255));
                end
                default: begin
                    weight = WEIGHT_W'($urandom_range(65536));
                end
            endcase
            send_attachment(bone, weight, i == count - 1);
        end
        if ($urandom_range(19) == 0) begin
            drain();
        end
    endtask

    task automatic random_phase(input int items);
        int start;
        start = items_sent;
        while (items_sent - start < items) begin
            send_random_vertex();
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_cloth(CLOTH_NONE);
        write_cloth(11'd5);

        send_attachment(10'd0, ONE_Q16, 1'b1);
        send_attachment(10'd5, 17'd40000, 1'b1);

        send_attachment(10'd1023, 17'd0, 1'b0);
        send_attachment(10'd5, ONE_Q16, 1'b0);
        send_attachment(10'h2AA, 17'd1, 1'b0);
        send_attachment(10'h155, 17'd65535, 1'b0);
        send_attachment(10'd7, 17'd12345, 1'b0);
        send_attachment(10'd8, 17'd0, 1'b1);

        for (int i = 0; i < 8; i++) begin
            send_attachment(10'(i), ONE_Q16, i == 7);
        end

        send_attachment(10'd9, 17'd0, 1'b0);
        send_attachment(10'd10, 17'd0, 1'b1);

        write_cloth(11'd0);
        random_phase(100);

        write_cloth(11'd1023);
        quiet_stretch = 1'b1;
        random_phase(100);
        quiet_stretch = 1'b0;

        write_cloth(11'($urandom_range(1022, 1)));
        random_phase(110);

        write_cloth(CLOTH_NONE);
        random_phase(110);

        drain();
        repeat (30) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            sb.report($sformatf("%0d expected beats never arrived", sb.expected_q.size()));
        end

        $display("Sent %0d attachments over %0d vertices under five cloth bone settings.",
                 items_sent, sb.vertices);
        $display("Checked %0d weights: %0d overflowed vertices, %0d zero sums, %0d cloth hits.",
                 sb.checked, sb.overflowed, sb.zero_sums, sb.cloth_hits);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
